[hdl/fsba_pkg.sv]
`timescale 1ns / 1ps
// Shared types and codes for the frame stack bitmap allocator.
// No dependencies; every other file of the block imports this package.
package fsba_pkg;

	localparam int unsigned FRAME_W  = 12;
	localparam int unsigned END_W    = 13;
	localparam int unsigned WORD_W   = 32;
	localparam int unsigned BIT_SEL_W = 5;

	typedef enum logic [1:0] {
		KIND_ADD     = 2'd0,
		KIND_ALLOC   = 2'd1,
		KIND_RELEASE = 2'd2,
		KIND_MARK    = 2'd3
	} fsba_kind_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_EMPTY    = 2'd1,
		ST_NOT_USED = 2'd2,
		ST_FULL     = 2'd3
	} fsba_status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_ADD,
		S_AL_POP,
		S_AL_MAP,
		S_AL_CHK,
		S_REL_CHK,
		S_MK_RD,
		S_MK_WR,
		S_DONE
	} fsba_state_t;

	typedef struct packed {
		fsba_kind_t           kind;
		logic [FRAME_W-1:0]   frame_number;
		logic [END_W-1:0]     end_frame;
	} fsba_req_t;

	typedef struct packed {
		logic [FRAME_W-1:0]   frame;
		fsba_status_t         status;
	} fsba_rsp_t;

	// Command from the sequencer to the free-frame stack.
	typedef struct packed {
		logic                 push;
		logic                 pop;
		logic [FRAME_W-1:0]   data;
	} fsba_stk_cmd_t;

	// Occupancy flags reported by the free-frame stack.
	typedef struct packed {
		logic                 empty;
		logic                 full;
	} fsba_stk_stat_t;

endpackage

[hdl/fsba_stack.sv]
`timescale 1ns / 1ps
// Free-frame stack: a single-port memory of frame numbers and its top pointer.
// Depends on fsba_pkg.
module fsba_stack import fsba_pkg::*; #(
	parameter int unsigned DEPTH = 4096
) (
	input  logic            clk,
	input  logic            arst_n,
	input  fsba_stk_cmd_t   cmd,
	output fsba_stk_stat_t  stat,
	output logic [FRAME_W-1:0] rd_data
);

	localparam int unsigned TW = $clog2(DEPTH + 1);
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [FRAME_W-1:0] mem [DEPTH];
	logic [TW-1:0]      top_q;
	logic [TW-1:0]      top_dec;
	logic [FRAME_W-1:0] rd_q;

	assign top_dec   = top_q - TW'(1);
	assign stat.full  = (top_q == TW'(DEPTH));
	assign stat.empty = (top_q == '0);
	assign rd_data   = rd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_q <= '0;
		end else if (cmd.push) begin
			top_q <= top_q + TW'(1);
		end else if (cmd.pop) begin
			top_q <= top_dec;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			mem[top_q[AW-1:0]] <= cmd.data;
		end
		if (cmd.pop) begin
			rd_q <= mem[top_dec[AW-1:0]];
		end
	end

endmodule

[hdl/fsba_bitmap.sv]
`timescale 1ns / 1ps
// Used-frame bitmap: 32-bit words in a memory with a registered read port,
// cleared by a sweep after reset. Depends on fsba_pkg.
module fsba_bitmap import fsba_pkg::*; #(
	parameter int unsigned WORDS = 128
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              rd_en,
	input  logic              wr_en,
	input  logic [((WORDS > 1) ? $clog2(WORDS) : 1)-1:0] addr,
	input  logic [WORD_W-1:0] wr_data,
	output logic [WORD_W-1:0] rd_data,
	output logic              busy
);

	localparam int unsigned AW = (WORDS > 1) ? $clog2(WORDS) : 1;

	logic [WORD_W-1:0] mem [WORDS];
	logic [WORD_W-1:0] rd_q;
	logic [AW-1:0]     clr_q;
	logic              busy_q;

	assign rd_data = rd_q;
	assign busy    = busy_q;

	// The clearing sweep walks every word once, one word per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
			clr_q  <= '0;
		end else if (busy_q) begin
			if (clr_q == AW'(WORDS - 1)) begin
				busy_q <= 1'b0;
			end
			clr_q <= clr_q + AW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q) begin
			mem[clr_q] <= '0;
		end else if (wr_en) begin
			mem[addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem[addr];
		end
	end

endmodule

[hdl/frame_stack_bitmap_allocator.sv]
`timescale 1ns / 1ps
// Frame stack bitmap allocator, top level: request sequencer and response register.
// Depends on fsba_pkg, fsba_stack and fsba_bitmap.
// Each request goes step by step: an add pushes the frames of its range one at a time;
// an allocate pops frames until one is free in the bitmap or the stack runs empty; a
// release reads one bitmap word unless its frame lies beyond the managed range; a mark
// reads and writes each word it touches. The shared stack and bitmap ports force this.
// One request is in flight at a time; the next is taken the cycle after the response
// is loaded. After reset a sweep clears each of the MAX_FRAMES/32 bitmap words.
module frame_stack_bitmap_allocator import fsba_pkg::*; #(
	parameter int unsigned MAX_FRAMES = 4096
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	output logic       req_ready,
	input  fsba_req_t  req,
	output logic       rsp_valid,
	input  logic       rsp_ready,
	output fsba_rsp_t  rsp
);

	// One bitmap word covers 32 frames.
	localparam int unsigned MAP_WORDS = (MAX_FRAMES + WORD_W - 1) / WORD_W;
	localparam int unsigned MAW       = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;

	fsba_state_t        state_q, state_d;
	logic [FRAME_W-1:0] first_q, first_d;
	logic [END_W-1:0]   end_q, end_d;
	logic [END_W-1:0]   cur_q, cur_d;
	logic [FRAME_W-1:0] res_frame_q, res_frame_d;
	fsba_status_t       res_status_q, res_status_d;
	fsba_rsp_t          rsp_q;
	logic               rsp_valid_q;
	logic               load_rsp;

	fsba_stk_cmd_t      stk_cmd;
	fsba_stk_stat_t     stk_stat;
	logic [FRAME_W-1:0] stk_rdata;

	logic               map_rd_en;
	logic               map_wr_en;
	logic [MAW-1:0]     map_addr;
	logic [WORD_W-1:0]  map_wdata;
	logic [WORD_W-1:0]  map_rdata;
	logic               map_busy;

	logic [END_W-1:0]   end_clip;
	logic               rel_range_bad;
	logic [END_W-1:0]   cur_dec;
	logic [WORD_W-1:0]  mark_mask;
	logic [WORD_W-1:0]  lo_mask;
	logic [WORD_W-1:0]  hi_mask;

	fsba_stack #(
		.DEPTH (MAX_FRAMES)
	) u_stack (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (stk_cmd),
		.stat    (stk_stat),
		.rd_data (stk_rdata)
	);

	fsba_bitmap #(
		.WORDS (MAP_WORDS)
	) u_bitmap (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (map_rd_en),
		.wr_en   (map_wr_en),
		.addr    (map_addr),
		.wr_data (map_wdata),
		.rd_data (map_rdata),
		.busy    (map_busy)
	);

	// A range never reaches past the last frame the block manages, and a release
	// of a frame beyond it is refused outright.
	assign end_clip = (32'(req.end_frame) < 32'(MAX_FRAMES)) ? req.end_frame
	                                                         : END_W'(MAX_FRAMES);
	assign rel_range_bad = (32'(req.frame_number) >= 32'(MAX_FRAMES));
	assign cur_dec = cur_q - END_W'(1);

	// Bits of the current bitmap word that fall inside the range being marked:
	// from the cursor up to the range end, or to the top of the word when the
	// range carries on into the next one.
	assign lo_mask   = {WORD_W{1'b1}} << cur_q[BIT_SEL_W-1:0];
	assign hi_mask   = (end_q[END_W-1:BIT_SEL_W] == cur_q[END_W-1:BIT_SEL_W])
	                 ? ~({WORD_W{1'b1}} << end_q[BIT_SEL_W-1:0]) : {WORD_W{1'b1}};
	assign mark_mask = lo_mask & hi_mask;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_rsp) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		first_q      <= first_d;
		end_q        <= end_d;
		cur_q        <= cur_d;
		res_frame_q  <= res_frame_d;
		res_status_q <= res_status_d;
		if (load_rsp) begin
			rsp_q.frame  <= res_frame_q;
			rsp_q.status <= res_status_q;
		end
	end

	always_comb begin
		state_d      = state_q;
		first_d      = first_q;
		end_d        = end_q;
		cur_d        = cur_q;
		res_frame_d  = res_frame_q;
		res_status_d = res_status_q;
		req_ready    = 1'b0;
		load_rsp     = 1'b0;
		stk_cmd      = '0;
		map_rd_en    = 1'b0;
		map_wr_en    = 1'b0;
		map_addr     = '0;
		map_wdata    = '0;

		unique case (state_q)
			S_IDLE: begin
				req_ready = !map_busy;
				if (req_valid && !map_busy) begin
					first_d      = req.frame_number;
					end_d        = end_clip;
					res_frame_d  = '0;
					res_status_d = ST_OK;
					unique case (req.kind)
						KIND_ADD: begin
							cur_d   = end_clip;
							state_d = S_ADD;
						end
						KIND_ALLOC: begin
							state_d = S_AL_POP;
						end
						KIND_RELEASE: begin
							if (rel_range_bad) begin
								res_status_d = ST_NOT_USED;
								state_d      = S_DONE;
							end else begin
								map_rd_en = 1'b1;
								map_addr  = MAW'(32'(req.frame_number) >> BIT_SEL_W);
								state_d   = S_REL_CHK;
							end
						end
						KIND_MARK: begin
							cur_d   = {1'b0, req.frame_number};
							state_d = S_MK_RD;
						end
						default: begin
							state_d = S_IDLE;
						end
					endcase
				end
			end
			// Frames go on from the highest down, so the lowest ends on top.
			S_ADD: begin
				if (cur_q > {1'b0, first_q}) begin
					if (stk_stat.full) begin
						res_status_d = ST_FULL;
						state_d      = S_DONE;
					end else begin
						stk_cmd.push = 1'b1;
						stk_cmd.data = cur_dec[FRAME_W-1:0];
						cur_d        = cur_dec;
					end
				end else begin
					state_d = S_DONE;
				end
			end
			S_AL_POP: begin
				if (stk_stat.empty) begin
					res_status_d = ST_EMPTY;
					state_d      = S_DONE;
				end else begin
					stk_cmd.pop = 1'b1;
					state_d     = S_AL_MAP;
				end
			end
			S_AL_MAP: begin
				map_rd_en = 1'b1;
				map_addr  = MAW'(32'(stk_rdata) >> BIT_SEL_W);
				state_d   = S_AL_CHK;
			end
			// A popped frame whose bit is already set is stale and is dropped.
			S_AL_CHK: begin
				map_addr = MAW'(32'(stk_rdata) >> BIT_SEL_W);
				if (!map_rdata[stk_rdata[BIT_SEL_W-1:0]]) begin
					map_wr_en    = 1'b1;
					map_wdata    = map_rdata
					             | (WORD_W'(1) << stk_rdata[BIT_SEL_W-1:0]);
					res_frame_d  = stk_rdata;
					res_status_d = ST_OK;
					state_d      = S_DONE;
				end else begin
					state_d = S_AL_POP;
				end
			end
			S_REL_CHK: begin
				map_addr = MAW'(32'(first_q) >> BIT_SEL_W);
				if (!map_rdata[first_q[BIT_SEL_W-1:0]]) begin
					res_status_d = ST_NOT_USED;
				end else if (stk_stat.full) begin
					res_status_d = ST_FULL;
				end else begin
					stk_cmd.push = 1'b1;
					stk_cmd.data = first_q;
					map_wr_en    = 1'b1;
					map_wdata    = map_rdata
					             & ~(WORD_W'(1) << first_q[BIT_SEL_W-1:0]);
				end
				state_d = S_DONE;
			end
			S_MK_RD: begin
				if (cur_q < end_q) begin
					map_rd_en = 1'b1;
					map_addr  = MAW'(32'(cur_q) >> BIT_SEL_W);
					state_d   = S_MK_WR;
				end else begin
					state_d = S_DONE;
				end
			end
			S_MK_WR: begin
				map_wr_en = 1'b1;
				map_addr  = MAW'(32'(cur_q) >> BIT_SEL_W);
				map_wdata = map_rdata | mark_mask;
				cur_d     = {cur_q[END_W-1:BIT_SEL_W] + (END_W - BIT_SEL_W)'(1),
				             {BIT_SEL_W{1'b0}}};
				state_d   = S_MK_RD;
			end
			// The result waits here until the response register is free.
			S_DONE: begin
				if (!rsp_valid_q || rsp_ready) begin
					load_rsp = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// The stack is never pushed when full, nor pushed and popped together.
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		stk_cmd.push |-> !stk_stat.full)
		else $error("push issued to a full stack");

	a_no_push_pop: assert property (@(posedge clk) disable iff (!arst_n)
		!(stk_cmd.push && stk_cmd.pop))
		else $error("push and pop in the same cycle");

	// The bitmap belongs to the clearing sweep until it is done.
	a_no_map_during_clear: assert property (@(posedge clk) disable iff (!arst_n)
		map_busy |-> !(map_rd_en || map_wr_en || req_ready))
		else $error("bitmap used during the clearing sweep");

	// A response appears only after the sequencer has finished a request.
	a_rsp_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q) == S_DONE)
		else $error("response raised outside the completion step");

endmodule

[verif/fsba_tb_pkg.sv]
`timescale 1ns / 1ps
// Scoreboard class for the frame stack bitmap allocator testbench.
// Depends on fsba_pkg for the request and response types and the status codes.
package fsba_tb_pkg;
	import fsba_pkg::*;

	localparam int unsigned TB_FRAMES = 4096;
	localparam int unsigned MAP_WORDS = TB_FRAMES / WORD_W;

	class alloc_scoreboard;
		logic [FRAME_W-1:0] free_frames [TB_FRAMES];
		int unsigned        stack_depth;
		logic [WORD_W-1:0]  used_map [MAP_WORDS];
		fsba_rsp_t          awaited_rsps [$];
		int unsigned        responses_seen;
		int unsigned        mismatches;

		function new();
			stack_depth = 0;
			responses_seen = 0;
			mismatches = 0;
			foreach (used_map[i]) used_map[i] = '0;
		endfunction

		function bit in_use(int unsigned f);
			return used_map[f / WORD_W][f % WORD_W];
		endfunction

		function void set_use(int unsigned f, bit v);
			used_map[f / WORD_W][f % WORD_W] = v;
		endfunction

		function bit push_free(int unsigned f);
			if (stack_depth >= TB_FRAMES) return 1'b0;
			free_frames[stack_depth] = FRAME_W'(f);
			stack_depth++;
			return 1'b1;
		endfunction

		function int unsigned outstanding();
			return awaited_rsps.size();
		endfunction

		// Advances the allocator state by one accepted request and queues its answer.
		function fsba_rsp_t note_request(fsba_req_t r);
			int unsigned first;
			int unsigned last_end;
			int unsigned f;
			fsba_rsp_t   ans;
			first = 32'(r.frame_number);
			last_end = (32'(r.end_frame) > TB_FRAMES) ? TB_FRAMES : 32'(r.end_frame);
			ans.frame = '0;
			ans.status = ST_OK;
			case (r.kind)
			KIND_ADD: begin
				for (f = last_end; f > first; f--) begin
					if (!push_free(f - 1)) begin
						ans.status = ST_FULL;
						break;
					end
				end
			end
			KIND_ALLOC: begin
				ans.status = ST_EMPTY;
				while (stack_depth > 0) begin
					stack_depth--;
					f = 32'(free_frames[stack_depth]);
					if (!in_use(f)) begin
						set_use(f, 1'b1);
						ans.frame = FRAME_W'(f);
						ans.status = ST_OK;
						break;
					end
				end
			end
			KIND_RELEASE: begin
				if (first >= TB_FRAMES || !in_use(first)) begin
					ans.status = ST_NOT_USED;
				end else if (!push_free(first)) begin
					ans.status = ST_FULL;
				end else begin
					set_use(first, 1'b0);
				end
			end
			default: begin
				for (f = first; f < last_end; f++) set_use(f, 1'b1);
			end
			endcase
			awaited_rsps.push_back(ans);
			return ans;
		endfunction

		task report(string what);
			$display("ERROR: response %0d: %s", responses_seen, what);
			mismatches++;
		endtask

		task check_response(fsba_rsp_t got);
			fsba_rsp_t want;
			responses_seen++;
			if (awaited_rsps.size() == 0) begin
				report($sformatf("unexpected response, frame %0d status %0d",
					got.frame, got.status));
				return;
			end
			want = awaited_rsps.pop_front();
			if (got.frame !== want.frame)
				report($sformatf("frame %0d, expected %0d", got.frame, want.frame));
			if (got.status !== want.status)
				report($sformatf("status %0d, expected %0d", got.status, want.status));
		endtask
	endclass

endpackage

[verif/tb_frame_stack_bitmap_allocator.sv]
`timescale 1ns / 1ps
// Self-checking testbench for frame_stack_bitmap_allocator.
// Depends on fsba_pkg and on fsba_tb_pkg, which holds the scoreboard class.
module tb_frame_stack_bitmap_allocator;
	import fsba_pkg::*;
	import fsba_tb_pkg::*;

	// Pushes and pops are bounded by the frames added, a few tens of thousands at
	// most; the limit leaves a wide margin for the clearing sweep, long allocate
	// pops and stalls.
	localparam int unsigned CYCLE_LIMIT  = 2000000;
	localparam int unsigned TAIL_CYCLES  = 64;
	localparam int unsigned RANDOM_ITEMS = 600;
	localparam int unsigned QUIET_ITEMS  = 80;

	logic      clk;
	logic      arst_n;
	logic      req_valid;
	logic      req_ready;
	fsba_req_t req;
	logic      rsp_valid;
	logic      rsp_ready;
	fsba_rsp_t rsp;

	alloc_scoreboard alloc_sb;

	// Odds of an idle burst on either side: one in idle_odds, or never when zero.
	int unsigned idle_odds = 3;
	int unsigned cycle_count = 0;

	frame_stack_bitmap_allocator #(
		.MAX_FRAMES(TB_FRAMES)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp)
	);

	initial clk = 1'b0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Watchdog: a hung handshake must not leave the simulation running forever.
	always @(posedge clk) begin
		cycle_count = cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// Response side. Every transfer is checked against the oldest expected answer,
	// using the values that were present at the clock edge. Ready is dropped in
	// short random bursts whenever idling is enabled for the current phase.
	initial begin
		int unsigned stall_left;
		stall_left = 0;
		rsp_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && rsp_valid && rsp_ready) alloc_sb.check_response(rsp);
			if (stall_left > 0) begin
				stall_left--;
				rsp_ready <= 1'b0;
			end else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
				stall_left = $urandom_range(0, 3);
				rsp_ready <= 1'b0;
			end else begin
				rsp_ready <= 1'b1;
			end
		end
	end

	// Presents one request and holds it until the transfer happens, then lets the
	// scoreboard predict the answer. Valid is only lowered when an idle burst is
	// inserted, so back-to-back requests keep valid high across the boundary.
	task automatic issue(input fsba_kind_t kind, input int unsigned first,
		input int unsigned stop_at, output fsba_rsp_t predicted);
		fsba_req_t r;
		r.kind = kind;
		r.frame_number = FRAME_W'(first);
		r.end_frame = END_W'(stop_at);
		if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		req <= r;
		req_valid <= 1'b1;
		do @(posedge clk); while (!req_ready);
		predicted = alloc_sb.note_request(r);
	endtask

	// Holds the request side quiet until every expected response has arrived.
	task automatic wait_drained();
		req_valid <= 1'b0;
		while (alloc_sb.outstanding() != 0) @(posedge clk);
	endtask

	// Looks for a frame currently marked in use near a random start point, so that
	// most releases succeed rather than being rejected as not in use.
	function automatic int unsigned pick_used_frame();
		int unsigned start;
		int unsigned f;
		start = $urandom_range(0, TB_FRAMES - 1);
		for (int unsigned i = 0; i < 64; i++) begin
			f = (start + i) % TB_FRAMES;
			if (alloc_sb.in_use(f)) return f;
		end
		return start;
	endfunction

	initial begin
		fsba_rsp_t   answer;
		int unsigned choice;
		int unsigned first;
		int unsigned stop_at;
		alloc_sb = new();
		arst_n <= 1'b0;
		req_valid <= 1'b0;
		req <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part. The block sweeps its bitmap clear after reset; the first
		// request simply waits for ready.
		// Allocate from a stack that has never been filled, and release a free frame.
		issue(KIND_ALLOC, 0, 0, answer);
		issue(KIND_RELEASE, 7, 0, answer);
		// Reversed and empty ranges change nothing.
		issue(KIND_ADD, 20, 10, answer);
		issue(KIND_ADD, 5, 5, answer);
		issue(KIND_MARK, 100, 50, answer);
		// A small range, two of its frames marked used so that an allocate has to
		// pop and discard them before it finds a free one.
		issue(KIND_ADD, 0, 8, answer);
		issue(KIND_MARK, 2, 4, answer);
		issue(KIND_ALLOC, 4095, 8191, answer);
		issue(KIND_ALLOC, 0, 0, answer);
		issue(KIND_ALLOC, 0, 0, answer);
		// Release, then release the same frame again while it is already free.
		issue(KIND_RELEASE, 1, 0, answer);
		issue(KIND_RELEASE, 1, 4096, answer);
		issue(KIND_ALLOC, 0, 0, answer);
		// A range running past the top of memory is clipped.
		issue(KIND_ADD, 4090, 8191, answer);
		issue(KIND_ALLOC, 0, 0, answer);
		issue(KIND_MARK, 4095, 4096, answer);
		// Fill the stack: the add stops part way, then both an add and a release of
		// a frame in use are refused while the stack is full.
		issue(KIND_ADD, 0, 4096, answer);
		issue(KIND_RELEASE, 4, 0, answer);
		issue(KIND_ADD, 100, 102, answer);
		// Mark everything used; the next allocate drains the whole stack and
		// reports it empty.
		issue(KIND_MARK, 0, 8191, answer);
		issue(KIND_ALLOC, 0, 0, answer);
		issue(KIND_RELEASE, 4095, 0, answer);
		issue(KIND_RELEASE, 4095, 0, answer);
		issue(KIND_ALLOC, 0, 0, answer);

		// Let everything settle once before the random part starts.
		wait_drained();

		for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
			if (n >= RANDOM_ITEMS - QUIET_ITEMS) begin
				idle_odds = 0;
			end else if (n % 50 == 0) begin
				case ($urandom_range(0, 2))
				0: idle_odds = 0;
				1: idle_odds = 3;
				default: idle_odds = 6;
				endcase
			end
			if ($urandom_range(0, 99) == 0) wait_drained();
			choice = $urandom_range(0, 99);
			if (choice < 30) begin
				// The range fields are ignored by an allocate, but still toggled.
				issue(KIND_ALLOC, $urandom_range(0, 4095), $urandom_range(0, 8191), answer);
			end else if (choice < 40) begin
				// Allocate and hand the same frame straight back.
				issue(KIND_ALLOC, 0, 0, answer);
				if (answer.status == ST_OK)
					issue(KIND_RELEASE, 32'(answer.frame), $urandom_range(0, 8191), answer);
			end else if (choice < 65) begin
				if ($urandom_range(0, 3) == 0)
					first = $urandom_range(0, 4095);
				else
					first = pick_used_frame();
				issue(KIND_RELEASE, first, $urandom_range(0, 8191), answer);
			end else begin
				// Ranges are mostly short; a few are reversed and a rare one is huge.
				first = $urandom_range(0, 4095);
				if ($urandom_range(0, 39) == 0)
					stop_at = $urandom_range(first, 8191);
				else if ($urandom_range(0, 9) == 0)
					stop_at = $urandom_range(0, first);
				else
					stop_at = first + $urandom_range(0, (choice < 85) ? 16 : 40);
				issue((choice < 85) ? KIND_ADD : KIND_MARK, first, stop_at, answer);
			end
		end

		req_valid <= 1'b0;
		while (alloc_sb.outstanding() != 0) @(posedge clk);
		// A short tail catches any response the block sends without a request.
		repeat (TAIL_CYCLES) @(posedge clk);
		if (alloc_sb.mismatches == 0 && alloc_sb.outstanding() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
